// ===== design/voice_allocator_oldest_steal_top_macros.svh =====
// Assertion helpers for the voice allocator controller (vas_ctrl).
// Each expects clk and rst_n in scope.
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_TOP_MACROS_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_TOP_MACROS_SVH

// Same-cycle implication.
`define VAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vas_pkg.sv =====
package vas_pkg;

  localparam int TIME_W = 48;

  localparam logic [2:0] REQ_BLOCK = 3'd0;
  localparam logic [2:0] REQ_ON    = 3'd1;
  localparam logic [2:0] REQ_OFF   = 3'd2;
  localparam logic [2:0] REQ_CUT   = 3'd3;
  localparam logic [2:0] REQ_FIN   = 3'd4;

  localparam logic [1:0] STG_UNUSED    = 2'd0;
  localparam logic [1:0] STG_ACTIVE    = 2'd1;
  localparam logic [1:0] STG_RELEASING = 2'd2;
  localparam logic [1:0] STG_FINISHING = 2'd3;

  localparam logic signed [31:0] ID_NONE = -32'sd1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [11:0]        frame;
    logic [12:0]        block_frames;
    logic signed [31:0] note_id;
    logic [6:0]         note_key;
    logic [3:0]         note_channel;
    logic [4:0]         voice_index;
  } in_t;

  typedef struct packed {
    logic [4:0]  assigned_voice;
    logic        was_stolen;
    logic [31:0] changed_mask;
    logic [5:0]  active_count;
    logic        no_match;
  } out_t;

  typedef struct packed {
    logic [1:0]         stage;
    logic [TIME_W-1:0]  start_time;
    logic signed [31:0] note_id;
    logic [6:0]         key;
    logic [3:0]         channel;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    stage:      STG_UNUSED,
    start_time: '0,
    note_id:    ID_NONE,
    key:        '0,
    channel:    '0
  };

  // Item as handed from the front end to the scan controller.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [TIME_W-1:0]  ev_time;
    logic signed [31:0] note_id;
    logic [6:0]         note_key;
    logic [3:0]         note_channel;
    logic [4:0]         voice_index;
  } job_t;

  // Table command from controller to voice table.
  typedef struct packed {
    logic   wr_en;
    logic   free_en;
    entry_t wr_data;
  } tcmd_t;

endpackage

// ===== design/vas_table.sv =====
module vas_table #(
  parameter int VOICES = 32,
  parameter int IDX_W  = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    rd_addr,
  output vas_pkg::entry_t     rd_data,
  input  logic [IDX_W-1:0]    cmd_addr,
  input  vas_pkg::tcmd_t      cmd
);

  vas_pkg::entry_t mem_r [VOICES];
  logic [VOICES-1:0] valid_r;
  vas_pkg::entry_t rd_q_r;
  logic rd_v_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[cmd_addr] <= cmd.wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
    rd_v_r <= valid_r[rd_addr];
  end

  // A freed or never-written entry reads back as the reset voice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd_addr] <= 1'b1;
    end else if (cmd.free_en) begin
      valid_r[cmd_addr] <= 1'b0;
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : vas_pkg::RESET_ENTRY;

endmodule

// ===== design/vas_ctrl.sv =====
`include "voice_allocator_oldest_steal_top_macros.svh"

module vas_ctrl #(
  parameter int VOICES = 32,
  parameter int IDX_W  = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  vas_pkg::job_t       job,
  output logic                busy,
  output logic                res_done,
  input  logic                res_load,
  output vas_pkg::out_t       res,
  output logic [IDX_W-1:0]    rd_addr,
  input  vas_pkg::entry_t     rd_data,
  output logic [IDX_W-1:0]    cmd_addr,
  output vas_pkg::tcmd_t      tcmd
);

  localparam int CNT_W = $clog2(VOICES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic pvld_r;
  logic [IDX_W-1:0] pidx_r;
  vas_pkg::job_t job_r;

  logic found_r, found_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] min_slot_r, min_slot_nxt;
  logic [vas_pkg::TIME_W-1:0] min_time_r, min_time_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [5:0] count_r, count_nxt;
  logic any_r, any_nxt;

  logic issue;
  logic [6:0] pidx_x;
  logic [31:0] pbit;
  logic id_hit;
  logic is_live;
  logic [IDX_W-1:0] take_slot;

  assign issue     = (state_r == S_SCAN) && (cnt_r < CNT_W'(VOICES));
  assign rd_addr   = issue ? cnt_r[IDX_W-1:0] : '0;
  assign pidx_x    = 7'(pidx_r);
  assign pbit      = (pidx_x < 7'd32) ? (32'd1 << pidx_x[4:0]) : 32'd0;
  assign take_slot = found_r ? slot_r : min_slot_r;
  assign cmd_addr  = (state_r == S_DONE) ? take_slot : pidx_r;
  assign is_live   = (rd_data.stage == vas_pkg::STG_ACTIVE) ||
                     (rd_data.stage == vas_pkg::STG_RELEASING);
  assign id_hit    = (job_r.note_id != vas_pkg::ID_NONE) ?
                     (rd_data.note_id == job_r.note_id) :
                     ((rd_data.key == job_r.note_key) &&
                      (rd_data.channel == job_r.note_channel));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    slot_nxt     = slot_r;
    min_slot_nxt = min_slot_r;
    min_time_nxt = min_time_r;
    mask_nxt     = mask_r;
    count_nxt    = count_r;
    any_nxt      = any_r;
    tcmd.wr_en   = 1'b0;
    tcmd.free_en = 1'b0;
    tcmd.wr_data = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          mask_nxt  = '0;
          count_nxt = '0;
          any_nxt   = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
        // Work on the entry whose read was issued last cycle.
        if (pvld_r) begin
          case (job_r.req_type) inside
            vas_pkg::REQ_BLOCK: begin
              if (is_live) begin
                if (count_r != 6'd63) begin
                  count_nxt = count_r + 6'd1;
                end
              end else if (rd_data.stage == vas_pkg::STG_FINISHING) begin
                tcmd.free_en = 1'b1;
                mask_nxt     = mask_r | pbit;
              end
            end
            vas_pkg::REQ_ON: begin
              if (!found_r && rd_data.stage == vas_pkg::STG_UNUSED) begin
                found_nxt = 1'b1;
                slot_nxt  = pidx_r;
              end
              // Oldest start time wins; strict compare keeps the first on ties.
              if (pidx_r == '0 || rd_data.start_time < min_time_r) begin
                min_time_nxt = rd_data.start_time;
                min_slot_nxt = pidx_r;
              end
            end
            vas_pkg::REQ_OFF, vas_pkg::REQ_CUT: begin
              if (rd_data.stage == vas_pkg::STG_ACTIVE &&
                  rd_data.start_time < job_r.ev_time && id_hit) begin
                tcmd.wr_en         = 1'b1;
                tcmd.wr_data.stage = (job_r.req_type == vas_pkg::REQ_CUT) ?
                                     vas_pkg::STG_FINISHING : vas_pkg::STG_RELEASING;
                mask_nxt           = mask_r | pbit;
                any_nxt            = 1'b1;
              end
            end
            vas_pkg::REQ_FIN: begin
              if (pidx_x == 7'(job_r.voice_index) && is_live) begin
                tcmd.wr_en         = 1'b1;
                tcmd.wr_data.stage = vas_pkg::STG_FINISHING;
                mask_nxt           = mask_r | pbit;
              end
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        // Place the new note; repeating the write while held is harmless.
        if (job_r.req_type == vas_pkg::REQ_ON) begin
          tcmd.wr_en                = 1'b1;
          tcmd.wr_data.stage        = vas_pkg::STG_ACTIVE;
          tcmd.wr_data.start_time   = job_r.ev_time;
          tcmd.wr_data.note_id      = job_r.note_id;
          tcmd.wr_data.key          = job_r.note_key;
          tcmd.wr_data.channel      = job_r.note_channel;
        end
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pvld_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= cnt_r[IDX_W-1:0];
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    min_slot_r <= min_slot_nxt;
    min_time_r <= min_time_nxt;
    mask_r     <= mask_nxt;
    count_r    <= count_nxt;
    any_r      <= any_nxt;
    if (start && state_r == S_IDLE) begin
      job_r <= job;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign res_done = (state_r == S_DONE);

  always_comb begin
    res.assigned_voice = (job_r.req_type == vas_pkg::REQ_ON) ? 5'(take_slot) : 5'd0;
    res.was_stolen     = (job_r.req_type == vas_pkg::REQ_ON) && !found_r;
    res.changed_mask   = mask_r;
    res.active_count   = count_r;
    res.no_match       = ((job_r.req_type == vas_pkg::REQ_OFF) ||
                          (job_r.req_type == vas_pkg::REQ_CUT)) && !any_r;
  end

  `VAS_ASSERT_NOW(a_start_when_idle, start, state_r == S_IDLE, "item started while busy")
  `VAS_ASSERT_NOW(a_wr_free_excl, tcmd.wr_en, !tcmd.free_en, "write and free together")
  `VAS_ASSERT_NOW(a_idle_quiet, state_r == S_IDLE, !pvld_r && !tcmd.wr_en, "table busy in idle")
  `VAS_ASSERT_NEXT(a_scan_bound, state_r == S_SCAN && !issue, state_r == S_DONE, "scan overran")

endmodule

// ===== design/voice_allocator_oldest_steal_top.sv =====
// After an input transfer the controller sweeps every voice table entry, and
// out_valid rises when the result enters the output register. A new item is taken
// only after the last, as the table's single read port is swept once per item.
// in_stall is high from the transfer until the result enters the output register.
// Reset (rst_n low, synchronous) empties the table and clears stream time at once.
module voice_allocator_oldest_steal_top #(
  parameter int VOICES    = 32,
  parameter int MAX_BLOCK = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vas_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vas_pkg::out_t  out_data
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [31:0] MAX_BLOCK_V = 32'(MAX_BLOCK);

  logic busy;
  logic in_acc;
  logic [vas_pkg::TIME_W-1:0] stream_time_r, stream_time_nxt;
  logic [12:0] blk_len_r, blk_len_nxt;
  vas_pkg::job_t job;
  logic res_done, res_load;
  vas_pkg::out_t res;
  logic out_valid_r, out_valid_nxt;
  vas_pkg::out_t out_data_r;

  logic [IDX_W-1:0] rd_addr, cmd_addr;
  vas_pkg::entry_t rd_data;
  vas_pkg::tcmd_t tcmd;

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  always_comb begin
    job.req_type     = in_data.req_type;
    job.ev_time      = stream_time_r + vas_pkg::TIME_W'(in_data.frame);
    job.note_id      = in_data.note_id;
    job.note_key     = in_data.note_key;
    job.note_channel = in_data.note_channel;
    job.voice_index  = in_data.voice_index;
  end

  always_comb begin
    stream_time_nxt = stream_time_r;
    blk_len_nxt     = blk_len_r;
    if (in_acc && in_data.req_type == vas_pkg::REQ_BLOCK) begin
      stream_time_nxt = stream_time_r + vas_pkg::TIME_W'(blk_len_r);
      blk_len_nxt     = (32'(in_data.block_frames) > MAX_BLOCK_V) ?
                        13'(MAX_BLOCK_V) : in_data.block_frames;
    end
  end

  // Output register: take the result when empty or being drained.
  assign res_load = res_done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_time_r <= '0;
      blk_len_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      stream_time_r <= stream_time_nxt;
      blk_len_r     <= blk_len_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  vas_ctrl #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .job      (job),
    .busy     (busy),
    .res_done (res_done),
    .res_load (res_load),
    .res      (res),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .cmd_addr (cmd_addr),
    .tcmd     (tcmd)
  );

  vas_table #(
    .VOICES (VOICES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .cmd_addr (cmd_addr),
    .cmd      (tcmd)
  );

endmodule
